@@ src/ckbk_pkg.sv @@
package ckbk_pkg;

   // Pixel and field widths.
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned PIXEL_W = 4 * CHAN_W;
   localparam logic [CHAN_W-1:0] PIXEL_MAX = 8'd255;

   // Register widths and the configuration port.
   localparam int unsigned HUE_W   = 15;
   localparam int unsigned Q12_W   = 13;
   localparam int unsigned THR_W   = 9;
   localparam int unsigned CSR_W   = 15;
   localparam int unsigned INDEX_W = 2;

   // Register indexes.
   localparam logic [INDEX_W-1:0] REG_HUE        = 2'd0;
   localparam logic [INDEX_W-1:0] REG_SATURATION = 2'd1;
   localparam logic [INDEX_W-1:0] REG_VALUE      = 2'd2;
   localparam logic [INDEX_W-1:0] REG_THRESHOLD  = 2'd3;

   // Fixed-point constants: hue in 1/64 degree, saturation and value in Q12.
   localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
   localparam logic [11:0]      HUE_SECTOR = 12'd3840;
   localparam logic [Q12_W-1:0] Q12_ONE    = 13'd4096;
   // One times one sector, the numerator scale of every color term.
   localparam logic [23:0]      TERM_ONE   = 24'd15728640;

   // The four color terms of the six-sector conversion.
   localparam int unsigned TERM_W = 2;
   localparam logic [TERM_W-1:0] TERM_V = 2'd0;
   localparam logic [TERM_W-1:0] TERM_P = 2'd1;
   localparam logic [TERM_W-1:0] TERM_Q = 2'd2;
   localparam logic [TERM_W-1:0] TERM_T = 2'd3;

   // Sequencer that rebuilds the key box after a register write.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL1,
      ST_MUL2,
      ST_SCALE,
      ST_BOUND
   } seq_state_type;

   // Start of hue sector n, for n from 0 to 6.
   function automatic logic [HUE_W-1:0] sector_base(input logic [2:0] n);
      logic [HUE_W-1:0] base;
      base = 15'({3'b0, HUE_SECTOR} * {12'b0, n});
      return base;
   endfunction

endpackage

@@ src/chroma_key_box_keyer.sv @@
// Chroma key box keyer.
// Pixels enter on the req_ stream (one per request) and leave on the rsp_
// stream with red, green and blue unchanged; alpha is forced to zero when all
// three channels fall inside the key box, else the input alpha passes.
// The key color is set as hue, saturation and value through the csr_ write
// port; the threshold sets the full width of the box on each channel.
// Throughput is one pixel per cycle when the receiver keeps up and no rebuild
// runs; responses pass through the three-stage match pipeline.
// After each register write the box is rebuilt by a sequencer that shares
// one multiplier pair over the four color terms: req_tready stays low from
// the write until the sequencer is idle again; then the new box is in force.
// Reset clears the registers to zero, which gives a black key with a box of
// 0..0 on every channel, and empties the pipeline; no rebuild is needed.
// When the receiver stalls, results stay in the pipeline registers and the
// request side keeps accepting until all three stages are full, then
// req_tready drops; nothing is lost or repeated.
module chroma_key_box_keyer
   import ckbk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Request stream.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [PIXEL_W-1:0] req_tdata,   // red_in, green_in, blue_in, alpha_in
   // Response stream.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PIXEL_W-1:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   // Configuration write port.
   input  logic               csr_wen,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [HUE_W-1:0] hue_ff;
   logic [Q12_W-1:0] sat_ff;
   logic [Q12_W-1:0] val_ff;
   logic [THR_W-1:0] thr_ff;

   // Box rebuild sequencer.
   seq_state_type    state_ff, state_in;
   logic [TERM_W-1:0] term_cnt_ff;
   logic             prep_en, mul1_en, mul2_en, scale_en, bound_en;

   logic [2:0]       sector_ff, sector_in;
   logic [11:0]      rem_ff, rem_in;
   logic [Q12_W-1:0] s_ff, v_ff;
   logic [HUE_W-1:0] h_sat;
   logic [2:0]       sector_cnt;
   logic [HUE_W-1:0] rem_full;

   logic [11:0]      k_sel;
   logic [23:0]      prod_ff, prod_in;
   logic [23:0]      x_term;
   logic [36:0]      vx_ff, vx_in;
   logic [40:0]      scaled;
   logic [CHAN_W-1:0] term_ff [4];

   logic [CHAN_W-1:0] key_r, key_g, key_b;
   logic [THR_W-1:0]  half;
   logic [CHAN_W-1:0] lo_ff [3];
   logic [CHAN_W-1:0] hi_ff [3];
   logic [CHAN_W-1:0] lo_in [3];
   logic [CHAN_W-1:0] hi_in [3];

   // Match pipeline.
   logic               v1_ff, v2_ff, v3_ff;
   logic               rdy1, rdy2, rdy3;
   logic [PIXEL_W-1:0] pix1_ff, pix2_ff, out_ff;
   logic [2:0]         inside_ff, inside_in;

   // Lower bound of a channel window, clamped at zero.
   function automatic logic [CHAN_W-1:0] bound_lo(input logic [CHAN_W-1:0] key,
                                                  input logic [THR_W-1:0] hw);
      logic [THR_W-1:0] k9;
      logic [THR_W-1:0] diff;
      k9   = {1'b0, key};
      diff = k9 - hw;
      return (k9 > hw) ? diff[CHAN_W-1:0] : '0;
   endfunction

   // Upper bound of a channel window, clamped at full scale.
   function automatic logic [CHAN_W-1:0] bound_hi(input logic [CHAN_W-1:0] key,
                                                  input logic [THR_W-1:0] hw);
      logic [THR_W:0] sum;
      sum = {2'b0, key} + {1'b0, hw};
      return (sum > {2'b0, PIXEL_MAX}) ? PIXEL_MAX : sum[CHAN_W-1:0];
   endfunction

   // Register writes; an index decodes to exactly one register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff <= '0;
         sat_ff <= '0;
         val_ff <= '0;
         thr_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_HUE:        hue_ff <= csr_wdata[HUE_W-1:0];
            REG_SATURATION: sat_ff <= csr_wdata[Q12_W-1:0];
            REG_VALUE:      val_ff <= csr_wdata[Q12_W-1:0];
            REG_THRESHOLD:  thr_ff <= csr_wdata[THR_W-1:0];
            default:        ;
         endcase
      end
   end

   // Sequencer next state; any write restarts the rebuild.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  state_in = ST_IDLE;
         ST_PREP:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_SCALE;
         ST_SCALE: state_in = (term_cnt_ff == TERM_T) ? ST_BOUND : ST_MUL1;
         ST_BOUND: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      if (csr_wen) begin
         state_in = ST_PREP;
      end
   end

   // Sequencer outputs.
   always_comb begin
      prep_en  = 1'b0;
      mul1_en  = 1'b0;
      mul2_en  = 1'b0;
      scale_en = 1'b0;
      bound_en = 1'b0;
      unique case (state_ff)
         ST_IDLE:  ;
         ST_PREP:  prep_en  = 1'b1;
         ST_MUL1:  mul1_en  = 1'b1;
         ST_MUL2:  mul2_en  = 1'b1;
         ST_SCALE: scale_en = 1'b1;
         ST_BOUND: bound_en = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         term_cnt_ff <= TERM_V;
      end else begin
         state_ff <= state_in;
         if (prep_en) begin
            term_cnt_ff <= TERM_V;
         end else if (scale_en) begin
            term_cnt_ff <= term_cnt_ff + 1'b1;
         end
      end
   end

   // Saturate the registers and split the hue into sector and remainder.
   always_comb begin
      h_sat      = (hue_ff > HUE_FULL) ? HUE_FULL : hue_ff;
      sector_cnt = '0;
      for (int i = 1; i <= 6; i++) begin
         sector_cnt = sector_cnt + 3'(h_sat >= sector_base(3'(i)));
      end
      rem_full = h_sat - sector_base(sector_cnt);
      // A full turn of hue is the last sector with no fraction.
      if (sector_cnt == 3'd6) begin
         sector_in = 3'd5;
         rem_in    = '0;
      end else begin
         sector_in = sector_cnt;
         rem_in    = rem_full[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (prep_en) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
         s_ff      <= (sat_ff > Q12_ONE) ? Q12_ONE : sat_ff;
         v_ff      <= (val_ff > Q12_ONE) ? Q12_ONE : val_ff;
      end
   end

   // Term x = one - s * k, k picked per term; then v * x; then
   // floor(v * x * 255 / (4096 * 4096 * 3840)) = (v * x * 17) >> 32.
   always_comb begin
      case (term_cnt_ff)
         TERM_V:  k_sel = '0;
         TERM_P:  k_sel = HUE_SECTOR;
         TERM_Q:  k_sel = rem_ff;
         default: k_sel = HUE_SECTOR - rem_ff;
      endcase
      prod_in = 24'({12'b0, s_ff} * {13'b0, k_sel});
      x_term  = TERM_ONE - prod_ff;
      vx_in   = {24'b0, v_ff} * {13'b0, x_term};
      scaled  = {vx_ff, 4'b0} + {4'b0, vx_ff};
   end

   always_ff @(posedge clock) begin
      if (mul1_en) begin
         prod_ff <= prod_in;
      end
      if (mul2_en) begin
         vx_ff <= vx_in;
      end
      if (scale_en) begin
         term_ff[term_cnt_ff] <= scaled[39:32];
      end
   end

   // Pick the channels for the sector and form the clamped windows.
   always_comb begin
      case (sector_ff)
         3'd0: begin
            key_r = term_ff[TERM_V]; key_g = term_ff[TERM_T]; key_b = term_ff[TERM_P];
         end
         3'd1: begin
            key_r = term_ff[TERM_Q]; key_g = term_ff[TERM_V]; key_b = term_ff[TERM_P];
         end
         3'd2: begin
            key_r = term_ff[TERM_P]; key_g = term_ff[TERM_V]; key_b = term_ff[TERM_T];
         end
         3'd3: begin
            key_r = term_ff[TERM_P]; key_g = term_ff[TERM_Q]; key_b = term_ff[TERM_V];
         end
         3'd4: begin
            key_r = term_ff[TERM_T]; key_g = term_ff[TERM_P]; key_b = term_ff[TERM_V];
         end
         default: begin
            key_r = term_ff[TERM_V]; key_g = term_ff[TERM_P]; key_b = term_ff[TERM_Q];
         end
      endcase
      // An odd threshold rounds the half width up.
      half     = 9'(({1'b0, thr_ff} + 10'd1) >> 1);
      lo_in[0] = bound_lo(key_r, half);
      hi_in[0] = bound_hi(key_r, half);
      lo_in[1] = bound_lo(key_g, half);
      hi_in[1] = bound_hi(key_g, half);
      lo_in[2] = bound_lo(key_b, half);
      hi_in[2] = bound_hi(key_b, half);
   end

   // The box resets to the black key with zero threshold.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            lo_ff[c] <= '0;
            hi_ff[c] <= '0;
         end
      end else if (bound_en) begin
         for (int c = 0; c < 3; c++) begin
            lo_ff[c] <= lo_in[c];
            hi_ff[c] <= hi_in[c];
         end
      end
   end

   // Each stage moves on when the stage after it is empty or moving.
   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1 && (state_ff == ST_IDLE);

   // Per-channel window compares on the stage one pixel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         inside_in[c] = (pix1_ff[c*CHAN_W +: CHAN_W] >= lo_ff[c]) &&
                        (pix1_ff[c*CHAN_W +: CHAN_W] <= hi_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_tvalid && req_tready;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pix1_ff <= req_tdata;
      end
      if (rdy2) begin
         pix2_ff   <= pix1_ff;
         inside_ff <= inside_in;
      end
      if (rdy3) begin
         out_ff[3*CHAN_W-1:0] <= pix2_ff[3*CHAN_W-1:0];
         out_ff[PIXEL_W-1:3*CHAN_W] <= (&inside_ff) ? '0 : pix2_ff[PIXEL_W-1:3*CHAN_W];
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = out_ff;

   // A write always holds off requests while the box is rebuilt.
   a_write_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> !req_tready)
      else $error("request accepted right after a register write");

   // Requests are only taken with the sequencer at rest.
   a_req_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (state_ff == ST_IDLE) && !bound_en)
      else $error("request accepted during a box rebuild");

   // Every window holds its lower bound at or below its upper bound.
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         (lo_ff[0] <= hi_ff[0]) && (lo_ff[1] <= hi_ff[1]) && (lo_ff[2] <= hi_ff[2]))
      else $error("key box bounds out of order");

endmodule
